@@ src/cht_pkg.sv @@
// Package: shared types and constants for the chained hash table.
`default_nettype none
package cht_pkg;
	localparam int BUCKETS_DEF = 256;
	localparam int ENTRIES_DEF = 256;
	localparam int CNT_W = 9;
	localparam int KEY_W = 32;
	localparam int VAL_W = 64;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_DELETE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MOD,
		S_HEAD,
		S_HEADW,
		S_RD,
		S_RDW,
		S_CHK,
		S_FIN,
		S_OUT
	} state_t;
endpackage
`default_nettype wire

@@ src/cht_mod.sv @@
// Module: iterative restoring remainder, one quotient bit per cycle.
`default_nettype none
module cht_mod import cht_pkg::*; #(
	parameter int DW = 64,
	parameter int NW = 13
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [NW-1:0] divisor,
	output logic               busy,
	output logic [NW-1:0]      rem
);
	localparam int CW = $clog2(DW + 1);
	logic [DW-1:0] dvd_q;
	logic [NW:0]   rem_q;
	logic [NW-1:0] dsr_q;
	logic [CW-1:0] cnt_q;
	logic [NW:0]   sh;
	logic [NW:0]   diff;

	assign sh   = {rem_q[NW-1:0], dvd_q[DW-1]};
	assign diff = sh - {1'b0, dsr_q};
	assign rem  = rem_q[NW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy  <= 1'b1;
			cnt_q <= CW'(DW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			rem_q <= diff[NW] ? sh : diff;
		end
	end
endmodule
`default_nettype wire

@@ src/chained_hash_table.sv @@
// Top level: chained hash table with sequencer, memories and remainder unit.
// Use: a command beat on s_axis (tdata = op, key, value) yields exactly one
// result beat on m_axis (tdata = status, found_value, stored_count).
// Config: cfg_we/cfg_wdata set the bucket count (0 acts as 1, above
// BUCKETS acts as BUCKETS); write only while idle.
// Steps from acceptance to m_axis_tvalid: the bucket remainder (one bit per
// cycle in the divider), the head lookup, a read of each chain entry visited
// (one read port, registered data), then write-back. Op 3 and an insert into a
// full pool go from the head lookup straight to the result.
// Throughput: one command at a time; s_axis_tready is low from acceptance
// until the result beat is taken.
// Reset: the bucket-head valid bits clear at once (all chains empty); the
// free list is an implicit counter of never-used entries plus a linked
// list of freed ones, so no clearing pass is needed.
// Stall: the result holds in the output register while m_axis_tready is low.
`default_nettype none
module chained_hash_table import cht_pkg::*; #(
	parameter int BUCKETS = BUCKETS_DEF,
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [8:0]   cfg_wdata,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [103:0] s_axis_tdata,  // op[1:0], key[33:2], value[97:34]
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [79:0]       m_axis_tdata   // status[1:0], found_value[65:2], stored_count[74:66]
);
	localparam int EW = $clog2(ENTRIES + 1);  // link width, null = ENTRIES
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int NW = $clog2(BUCKETS + 1);
	localparam logic [EW-1:0] NIL = EW'(ENTRIES);

	// memories
	logic [EW-1:0]    head_mem [BUCKETS];
	logic [BUCKETS-1:0] head_vld_q;
	logic [KEY_W-1:0] key_mem  [ENTRIES];
	logic [VAL_W-1:0] val_mem  [ENTRIES];
	logic [EW-1:0]    link_mem [ENTRIES];

	logic [8:0]    bcnt_q;
	logic [EW-1:0] fresh_q;     // next never-used entry
	logic [EW-1:0] fhead_q;     // freed list head
	logic [EW-1:0] fnext_q;     // link of freed list head
	logic [CNT_W-1:0] count_q;

	state_t st_q, st_d;
	logic [1:0]       op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [BW-1:0]    slot_q;
	logic [EW-1:0]    it_q, prev_q, hd_q, newe_q;
	logic [KEY_W-1:0] rkey_q;
	logic [VAL_W-1:0] rval_q;
	logic [EW-1:0]    rlink_q;
	logic             hit_q;

	logic [1:0]       o_status_q;
	logic [VAL_W-1:0] o_found_q;

	// deferred link writes, in the cycle after write-back
	logic [EW-1:0] link_tail_q;
	logic          tail_pend_q, free_pend_q;
	logic [EW-1:0] free_e_q;
	logic [EW-1:0] fhead_q_old_q;

	// divisor clamp
	logic [NW-1:0] dsr;
	always_comb begin
		if (bcnt_q == 9'd0) dsr = NW'(1);
		else if (32'(bcnt_q) > BUCKETS) dsr = NW'(BUCKETS);
		else dsr = NW'(bcnt_q);
	end

	logic mod_start, mod_busy;
	logic [NW-1:0] mod_rem;
	cht_mod #(.DW(64), .NW(NW)) u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start),
		.dividend({{32{s_axis_tdata[33]}}, s_axis_tdata[33:2]}),
		.divisor(dsr), .busy(mod_busy), .rem(mod_rem)
	);

	logic acc;
	assign s_axis_tready = (st_q == S_IDLE);
	assign acc = s_axis_tvalid && s_axis_tready;
	assign mod_start = acc;
	assign m_axis_tvalid = (st_q == S_OUT);
	assign m_axis_tdata = {5'd0, count_q, o_found_q, o_status_q};

	logic no_free;
	assign no_free = (fhead_q == NIL) && (fresh_q == NIL);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: if (acc) st_d = S_MOD;
			S_MOD:  if (!mod_busy) st_d = S_HEAD;
			S_HEAD: begin
				if (op_q == OP_NONE) st_d = S_OUT;
				else if (op_q == OP_INSERT && no_free) st_d = S_OUT;
				else st_d = S_HEADW;
			end
			S_HEADW: st_d = (hd_q == NIL) ? S_FIN : S_RD;
			S_RD:   st_d = S_RDW;
			S_RDW:  st_d = S_CHK;
			S_CHK: begin
				if (op_q == OP_INSERT) st_d = (rlink_q == NIL) ? S_FIN : S_RD;
				else if (rkey_q == key_q) st_d = S_FIN;
				else st_d = (rlink_q == NIL) ? S_FIN : S_RD;
			end
			S_FIN:  st_d = S_OUT;
			S_OUT:  if (m_axis_tready) st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			bcnt_q     <= 9'd256;
			head_vld_q <= '0;
			fresh_q    <= '0;
			fhead_q    <= NIL;
			count_q    <= '0;
		end else begin
			st_q <= st_d;
			if (cfg_we) bcnt_q <= cfg_wdata;
			if (st_q == S_FIN) begin
				if (op_q == OP_INSERT) begin
					if (fhead_q != NIL) fhead_q <= fnext_q;
					else fresh_q <= fresh_q + 1'b1;
					count_q <= count_q + 1'b1;
					if (hd_q == NIL) head_vld_q[slot_q] <= 1'b1;
				end else if (op_q == OP_DELETE && hit_q) begin
					fhead_q <= it_q;
					if (count_q != '0) count_q <= count_q - 1'b1;
				end
			end
		end
	end

	// datapath and memory ports
	always_ff @(posedge clk) begin
		if (acc) begin
			op_q  <= s_axis_tdata[1:0];
			key_q <= s_axis_tdata[33:2];
			val_q <= s_axis_tdata[97:34];
		end
		case (st_q)
			S_MOD: begin
				slot_q <= BW'(mod_rem);
			end
			S_HEAD: begin
				hd_q   <= head_vld_q[slot_q] ? head_mem[slot_q] : NIL;
				newe_q <= (fhead_q != NIL) ? fhead_q : fresh_q;
				hit_q  <= 1'b0;
				prev_q <= NIL;
				// read link of freed head for pop
				if (fhead_q != NIL) fnext_q <= link_mem[AW'(fhead_q)];
				o_status_q <= (op_q == OP_INSERT) ? (no_free ? ST_FULL : ST_DONE)
					: ((op_q == OP_NONE) ? ST_DONE : ST_MISS);
				o_found_q  <= '0;
			end
			S_HEADW: begin
				it_q <= hd_q;
				if (op_q == OP_INSERT) begin
					key_mem[AW'(newe_q)] <= key_q;
					val_mem[AW'(newe_q)] <= val_q;
				end
			end
			S_RD: begin
				rkey_q  <= key_mem[AW'(it_q)];
				rval_q  <= val_mem[AW'(it_q)];
				rlink_q <= link_mem[AW'(it_q)];
			end
			S_CHK: begin
				if (op_q == OP_INSERT) begin
					if (rlink_q != NIL) it_q <= rlink_q;
				end else if (rkey_q == key_q) begin
					hit_q      <= 1'b1;
					o_status_q <= ST_DONE;
					o_found_q  <= rval_q;
				end else begin
					prev_q <= it_q;
					it_q   <= rlink_q;
				end
			end
			S_FIN: begin
				if (op_q == OP_INSERT) begin
					link_mem[AW'(newe_q)] <= NIL;
					if (hd_q == NIL) head_mem[slot_q] <= newe_q;
				end else if (op_q == OP_DELETE && hit_q) begin
					if (prev_q == NIL) head_mem[slot_q] <= rlink_q;
					else link_mem[AW'(prev_q)] <= rlink_q;
				end
			end
			default: ;
		endcase
		// tail link and freed-entry link land the cycle after write-back
		if (tail_pend_q) link_mem[AW'(link_tail_q)] <= newe_q;
		else if (free_pend_q) link_mem[AW'(free_e_q)] <= fhead_q_old_q;
	end

	always_ff @(posedge clk) begin
		if (st_q == S_FIN && op_q == OP_INSERT && hd_q != NIL)
			link_tail_q <= it_q;
		if (st_q == S_FIN) begin
			free_e_q      <= it_q;
			fhead_q_old_q <= fhead_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_pend_q <= 1'b0;
			free_pend_q <= 1'b0;
		end else begin
			tail_pend_q <= (st_q == S_FIN && op_q == OP_INSERT && hd_q != NIL);
			free_pend_q <= (st_q == S_FIN && op_q == OP_DELETE && hit_q);
		end
	end
endmodule
`default_nettype wire

@@ tb/cht_checker.sv @@
// Checker: watches both streams, predicts each result and compares it.
`timescale 1ns / 100ps
`default_nettype none
module cht_checker import cht_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [8:0]   cfg_wdata,
	input  wire logic         s_axis_tvalid,
	input  wire logic         s_axis_tready,
	input  wire logic [103:0] s_axis_tdata,
	input  wire logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	input  wire logic [79:0]  m_axis_tdata,
	output int                errors,
	output int                pending
);
	localparam int NIL = ENTRIES_DEF;

	typedef struct packed {
		status_t     status;
		logic [63:0] found;
		logic [8:0]  count;
	} result_t;

	int          head [BUCKETS_DEF];
	logic [31:0] ekey [ENTRIES_DEF];
	logic [63:0] eval [ENTRIES_DEF];
	int          elink [ENTRIES_DEF];
	int          free_head;
	int          held;
	logic [8:0]  nbuckets;
	result_t     results_due [$];

	function automatic int bucket_of(logic [31:0] key);
		logic [63:0] k;
		logic [63:0] n;
		k = {{32{key[31]}}, key};
		n = (nbuckets == 0) ? 64'd1 : (nbuckets > BUCKETS_DEF) ? BUCKETS_DEF : nbuckets;
		return int'(k % n);
	endfunction

	task automatic table_op(op_t op, logic [31:0] key, logic [63:0] value);
		result_t r;
		int b, e, it, prev;
		r = '{ST_DONE, 64'd0, 9'd0};
		b = bucket_of(key);
		if (op == OP_INSERT) begin
			if (free_head >= NIL) begin
				r.status = ST_FULL;
			end else begin
				e = free_head;
				free_head = elink[e];
				ekey[e] = key;
				eval[e] = value;
				elink[e] = NIL;
				if (head[b] >= NIL) begin
					head[b] = e;
				end else begin
					it = head[b];
					while (elink[it] < NIL) it = elink[it];
					elink[it] = e;
				end
				held++;
			end
		end else if (op == OP_LOOKUP || op == OP_DELETE) begin
			r.status = ST_MISS;
			prev = NIL;
			it = head[b];
			while (it < NIL) begin
				if (ekey[it] == key) begin
					r.status = ST_DONE;
					r.found = eval[it];
					if (op == OP_DELETE) begin
						if (prev >= NIL) head[b] = elink[it];
						else elink[prev] = elink[it];
						elink[it] = free_head;
						free_head = it;
						if (held > 0) held--;
					end
					break;
				end
				prev = it;
				it = elink[it];
			end
		end
		r.count = held[8:0];
		results_due.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		if (!arst_n) begin
			for (int i = 0; i < BUCKETS_DEF; i++) head[i] = NIL;
			for (int i = 0; i < ENTRIES_DEF; i++) elink[i] = i + 1;
			free_head = 0;
			held = 0;
			nbuckets = 9'd256;
			results_due.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) nbuckets = cfg_wdata;
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{status_t'(m_axis_tdata[1:0]), m_axis_tdata[65:2], m_axis_tdata[74:66]};
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					errors <= errors + 1;
				end else begin
					want = results_due.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch exp st=%0d val=%h cnt=%0d got st=%0d val=%h cnt=%0d",
							$time, want.status, want.found, want.count,
							got.status, got.found, got.count);
						errors <= errors + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				table_op(op_t'(s_axis_tdata[1:0]), s_axis_tdata[33:2], s_axis_tdata[97:34]);
			pending <= results_due.size();
		end
	end
endmodule
`default_nettype wire

@@ tb/tb_chained_hash_table.sv @@
// Testbench top: drives commands and bucket counts, gives the verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_chained_hash_table;
	import cht_pkg::*;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [8:0]   cfg_wdata = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [103:0] s_axis_tdata = '0;   // op[1:0], key[33:2], value[97:34]
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [79:0]  m_axis_tdata;        // status[1:0], found_value[65:2], stored_count[74:66]
	int           errors;
	int           pending;

	// idle percentages per phase, and a long hold-off request
	int send_idle = 0;
	int recv_stall = 0;
	logic hold_req = 1'b0;
	logic hold_seen = 1'b0;
	int   hold_left = 0;

	// keys recently inserted, so lookups and deletes mostly hit
	logic [31:0] key_pool [$];

	chained_hash_table uut (.*);

	cht_checker chk (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("tb_chained_hash_table: errors");
		$finish;
	end

	// receiver: random stall, plus a long hold-off counted here
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// one command beat; sender gaps come before offering
	task automatic send_cmd(op_t op, logic [31:0] key, logic [63:0] value);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tdata <= {6'd0, value, key, op};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		if (op == OP_INSERT) begin
			key_pool.push_back(key);
			if (key_pool.size() > 40) void'(key_pool.pop_front());
		end
	endtask

	// wait for every result, then let the block settle before a register write
	task automatic set_buckets(logic [8:0] n);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		cfg_wdata <= n;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] pick_key();
		if (key_pool.size() != 0 && $urandom_range(99) < 70)
			return key_pool[$urandom_range(key_pool.size() - 1)];
		if ($urandom_range(1)) return 32'($signed($urandom_range(40)) - 20);
		return $urandom;
	endfunction

	task automatic random_phase(int n);
		int r;
		op_t op;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			op = (r < 45) ? OP_INSERT : (r < 75) ? OP_LOOKUP : (r < 97) ? OP_DELETE : OP_NONE;
			send_cmd(op, pick_key(), {$urandom, $urandom});
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme keys and values, every op, misses, duplicates
		send_cmd(OP_LOOKUP, 32'h8000_0000, '0);
		send_cmd(OP_DELETE, 32'h7fff_ffff, '0);
		send_cmd(OP_INSERT, 32'h8000_0000, '1);
		send_cmd(OP_INSERT, 32'h7fff_ffff, 64'd0);
		send_cmd(OP_INSERT, 32'hffff_ffff, 64'h5555_aaaa_5555_aaaa);
		send_cmd(OP_INSERT, 32'hffff_ffff, 64'haaaa_5555_aaaa_5555);
		send_cmd(OP_INSERT, 32'd0, 64'd7);
		send_cmd(OP_LOOKUP, 32'hffff_ffff, '1);
		send_cmd(OP_DELETE, 32'hffff_ffff, '0);
		send_cmd(OP_LOOKUP, 32'hffff_ffff, '0);
		send_cmd(OP_LOOKUP, 32'h8000_0000, '0);
		send_cmd(OP_NONE, 32'h7fff_ffff, '1);
		send_cmd(OP_DELETE, 32'd0, '0);
		send_cmd(OP_DELETE, 32'd12345, '0);

		// bucket count zero acts as one; keys from the last setting go stale
		set_buckets(9'd0);
		send_cmd(OP_LOOKUP, 32'h7fff_ffff, '0);
		send_cmd(OP_INSERT, 32'd99, 64'd1);
		send_cmd(OP_LOOKUP, 32'd99, '0);

		// pool full: fill all 256 entries with one bucket, then insert past full
		set_buckets(9'd1);
		for (int i = 0; i < 260; i++) send_cmd(OP_INSERT, $urandom, {$urandom, $urandom});
		random_phase(100);

		// above BUCKETS acts as BUCKETS; long hold-off while sender keeps pushing
		set_buckets(9'd511);
		hold_req <= ~hold_req;
		random_phase(150);
		recv_stall = 86;
		random_phase(120);
		set_buckets(9'd7);
		recv_stall = 0;
		send_idle = 86;
		random_phase(120);
		set_buckets(9'd256);
		send_idle = 32;
		recv_stall = 32;
		random_phase(200);
		set_buckets(9'd3);
		send_idle = 0;
		recv_stall = 0;
		random_phase(300);
		set_buckets(9'd2);
		random_phase(300);
		set_buckets(9'd255);
		recv_stall = 50;
		random_phase(300);

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("tb_chained_hash_table: clean");
		else
			$display("tb_chained_hash_table: errors");
		$finish;
	end
endmodule
`default_nettype wire
